### hdl/sct_pkg.sv
// ============================================================================
// sct_pkg
// Shared widths, types and the control struct for the quarter-wave sine and
// cosine generator.
// ============================================================================
package sct_pkg;

    // Word widths.
    localparam int ANGLE_W      = 16;
    localparam int OUT_W        = 16;
    localparam int ROM_W        = 16;

    // Table geometry: 2^SEG_BITS segments over one quadrant.
    localparam int SEG_BITS     = 5;
    localparam int SEGMENTS     = 1 << SEG_BITS;
    localparam int ROM_IDX_W    = SEG_BITS + 1;

    // One quadrant spans 2^QUARTER_BITS angle units.
    localparam int QUARTER_BITS = ANGLE_W - 2;
    localparam int FRAC_W       = QUARTER_BITS - SEG_BITS;
    localparam int FRAC_ONE     = 1 << FRAC_W;
    localparam int HALF_TURN    = 1 << (ANGLE_W - 1);
    localparam int QUARTER_TURN = 1 << QUARTER_BITS;

    // A weighted table entry, wide enough for the sum of two of them.
    localparam int PROD_W       = ROM_W + FRAC_W + 1;

    typedef logic        [ANGLE_W-1:0]   t_angle;
    typedef logic signed [OUT_W-1:0]     t_sample;
    typedef logic        [ROM_W-1:0]     t_rom_word;
    typedef logic        [ROM_IDX_W-1:0] t_rom_idx;
    typedef logic        [SEG_BITS-1:0]  t_seg;
    typedef logic        [FRAC_W:0]      t_frac;
    typedef logic        [PROD_W-1:0]    t_prod;

    // Load enables of the multiply and output stages of one interpolator.
    typedef struct packed {
        logic mul_en;
        logic out_en;
    } t_pipe_ctl;

endpackage

### hdl/sct_angle_if.sv
// ============================================================================
// sct_angle_if
// Valid/ready channel carrying one phase angle word.
// ============================================================================
interface sct_angle_if
    import sct_pkg::*;
;
    logic   valid;
    logic   ready;
    t_angle angle;

    modport source (output valid, output angle, input ready);
    modport sink   (input valid, input angle, output ready);
endinterface

### hdl/sct_result_if.sv
// ============================================================================
// sct_result_if
// Valid/ready channel carrying one sine and cosine pair.
// ============================================================================
interface sct_result_if
    import sct_pkg::*;
;
    logic    valid;
    logic    ready;
    t_sample sine;
    t_sample cosine;

    modport source (output valid, output sine, output cosine, input ready);
    modport sink   (input valid, input sine, input cosine, output ready);
endinterface

### hdl/sct_interp.sv
// ============================================================================
// sct_interp
// Linear interpolation between two table entries, followed by the quadrant
// sign and positive saturation. Two pipeline stages.
// ============================================================================
module sct_interp
    import sct_pkg::*;
(
    input  logic      i_clk,
    input  t_pipe_ctl i_ctl,
    input  t_rom_word i_lo,
    input  t_rom_word i_hi,
    input  t_frac     i_frac,
    input  logic      i_neg,
    output t_sample   o_value
);

    localparam int MAG_W = PROD_W - FRAC_W;

    t_prod             r_p_lo;
    t_prod             r_p_hi;
    logic              r_neg;
    t_sample           r_value;

    t_frac             w_frac_lo;
    t_prod             w_sum;
    logic [MAG_W-1:0]  w_mag;
    logic [MAG_W-1:0]  w_neg_mag;
    t_sample           n_value;

    assign w_frac_lo = t_frac'(FRAC_ONE) - i_frac;

    // Multiply stage: weight each neighbor by the point's distance to the other one.
    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_p_lo <= PROD_W'(i_lo) * PROD_W'(w_frac_lo);
            r_p_hi <= PROD_W'(i_hi) * PROD_W'(i_frac);
            r_neg  <= i_neg;
        end
    end

    // Output stage: round half up, then apply sign or saturate.
    always_comb begin
        w_sum     = r_p_lo + r_p_hi + t_prod'(FRAC_ONE / 2);
        w_mag     = w_sum[PROD_W-1:FRAC_W];
        w_neg_mag = '0 - w_mag;
        if (r_neg && (w_mag != '0)) begin
            n_value = t_sample'(w_neg_mag[OUT_W-1:0]);
        end else if (w_mag > MAG_W'((1 << (OUT_W - 1)) - 1)) begin
            n_value = t_sample'((1 << (OUT_W - 1)) - 1);
        end else begin
            n_value = t_sample'(w_mag[OUT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.out_en) begin
            r_value <= n_value;
        end
    end

    assign o_value = r_value;

endmodule

### hdl/sine_cosine_table_interp.sv
// ============================================================================
// sine_cosine_table_interp
// Quarter-wave sine and cosine generator with linear interpolation.
// ============================================================================
// The block takes 16-bit phase words (65536 units per turn, wrapping
// naturally) and returns the matching sine and cosine as signed Q1.15 words,
// with +1.0 saturated to 32767 and -1.0 kept as -32768. Each word is folded
// into the first quadrant and the 33-entry quarter-sine ROM is read
// synchronously, the two neighboring entries of each output are weighted by
// one multiplier pair, and the rounded sum is signed or saturated into the
// output register. The ROM port and the multipliers are fully pipelined, so
// unless the output stalls a new angle word is accepted in every cycle and a
// result word leaves in every cycle once the pipeline is full. Each stage
// advances on its own whenever the stage after it is free, so bubbles close
// up and the input keeps accepting words while a finished result waits at
// the output, until all stages are full. An exact quarter turn clamps to the
// last segment with a full fraction, so no read goes past the table. There
// is no state to clear after reset; only the stage valid flags reset.
// ============================================================================
module sine_cosine_table_interp
    import sct_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    sct_angle_if.sink           i_angle_ch,
    sct_result_if.source        o_result_ch
);

    // Quarter-wave sine ROM, unsigned Q1.15, entry SEGMENTS is 1.0.
    localparam t_rom_word QSINE [0:SEGMENTS] = '{
        16'd0,     16'd1608,  16'd3212,  16'd4808,  16'd6393,  16'd7962,
        16'd9512,  16'd11039, 16'd12540, 16'd14010, 16'd15447, 16'd16846,
        16'd18205, 16'd19520, 16'd20788, 16'd22006, 16'd23170, 16'd24279,
        16'd25330, 16'd26320, 16'd27246, 16'd28106, 16'd28899, 16'd29622,
        16'd30274, 16'd30853, 16'd31357, 16'd31786, 16'd32138, 16'd32413,
        16'd32610, 16'd32729, 16'd32768
    };

    // Stage valid flags and their load enables.
    logic      r_v1;
    logic      r_v2;
    logic      r_v3;
    logic      w_en1;
    logic      w_en2;
    logic      w_en3;

    // Fold and split of the incoming angle.
    t_angle                w_a;
    logic                  w_upper;
    t_angle                w_a1;
    logic                  w_folded;
    t_angle                w_mirror;
    logic [QUARTER_BITS:0] w_a2;
    logic                  w_full;
    t_seg                  w_k;
    t_frac                 w_g;
    t_rom_idx              w_idx;

    // ROM read stage registers.
    t_rom_word r1_s_lo;
    t_rom_word r1_s_hi;
    t_rom_word r1_c_lo;
    t_rom_word r1_c_hi;
    t_frac     r1_g;
    logic      r1_upper;
    logic      r1_folded;

    t_pipe_ctl w_ctl;
    t_sample   w_sine;
    t_sample   w_cosine;

    // A stage loads when it is empty or the stage after it moves on.
    assign w_en3 = !r_v3 || o_result_ch.ready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_angle_ch.ready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_angle_ch.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Fold into the first quadrant: the lower half turn stands for the
    // upper one with the sine sign flipped, and the second quadrant mirrors
    // onto the first with the cosine sign flipped.
    always_comb begin
        w_a      = i_angle_ch.angle;
        w_upper  = w_a > t_angle'(HALF_TURN);
        w_a1     = w_upper ? (w_a - t_angle'(HALF_TURN)) : w_a;
        w_folded = w_a1 > t_angle'(QUARTER_TURN);
        w_mirror = t_angle'(HALF_TURN) - w_a1;
        w_a2     = w_folded ? w_mirror[QUARTER_BITS:0] : w_a1[QUARTER_BITS:0];
        // A full quarter turn lands on the last segment at full weight.
        w_full   = w_a2[QUARTER_BITS];
        w_k      = w_full ? t_seg'(SEGMENTS - 1)
                          : w_a2[QUARTER_BITS-1 -: SEG_BITS];
        w_g      = w_full ? t_frac'(FRAC_ONE) : {1'b0, w_a2[FRAC_W-1:0]};
        w_idx    = {1'b0, w_k};
    end

    // Synchronous ROM read. The cosine walks the same table from the top.
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_s_lo   <= QSINE[w_idx];
            r1_s_hi   <= QSINE[w_idx + t_rom_idx'(1)];
            r1_c_lo   <= QSINE[t_rom_idx'(SEGMENTS) - w_idx];
            r1_c_hi   <= QSINE[t_rom_idx'(SEGMENTS - 1) - w_idx];
            r1_g      <= w_g;
            r1_upper  <= w_upper;
            r1_folded <= w_folded;
        end
    end

    assign w_ctl.mul_en = w_en2;
    assign w_ctl.out_en = w_en3;

    sct_interp u_sine (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_lo    (r1_s_lo),
        .i_hi    (r1_s_hi),
        .i_frac  (r1_g),
        .i_neg   (r1_upper),
        .o_value (w_sine)
    );

    sct_interp u_cosine (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_lo    (r1_c_lo),
        .i_hi    (r1_c_hi),
        .i_frac  (r1_g),
        .i_neg   (r1_upper ^ r1_folded),
        .o_value (w_cosine)
    );

    assign o_result_ch.valid  = r_v3;
    assign o_result_ch.sine   = w_sine;
    assign o_result_ch.cosine = w_cosine;

    // An accepted angle word always lands in the ROM read stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_angle_ch.valid && i_angle_ch.ready) |=> r_v1)
        else $error("accepted angle word did not enter the pipeline");

    // A stalled output must not let the middle stage be overwritten.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !o_result_ch.ready) |=> r_v2)
        else $error("multiply stage lost a word under output stall");

    // The input only stalls when every stage holds a word.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_angle_ch.ready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled while the pipeline had room");

    // Sine and cosine can never both be zero.
    a_not_both_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_ch.valid |-> !((w_sine == '0) && (w_cosine == '0)))
        else $error("sine and cosine both zero");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Self-checking bench for the quarter-wave sine and cosine generator.
// ============================================================================
// Angle words are queued by the stimulus process and offered by a driver on
// the falling clock edge. Every word taken by the block is run through a
// local predictor right away: quadrant folding, table interpolation with
// rounding, and the sign or saturation step. The predicted sine and cosine
// are queued in order. A monitor compares each result word taken at the
// output with the oldest prediction, field by field. The run has three
// phases with different idle patterns on both sides. During the last phase
// the output is held off for a long stretch so the pipeline fills up and
// stalls its input.
// ============================================================================
module tb;
    import sct_pkg::*;

    localparam int CLK_HALF_NS   = 6;
    localparam int RESET_CYCLES  = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 2_000_000;

    // Quarter-wave sine table, unsigned Q1.15 with 1.0 = 32768.
    localparam int unsigned QUARTER_WAVE [0:SEGMENTS] = '{
        0, 1608, 3212, 4808, 6393, 7962, 9512, 11039,
        12540, 14010, 15447, 16846, 18205, 19520, 20788, 22006,
        23170, 24279, 25330, 26320, 27246, 28106, 28899, 29622,
        30274, 30853, 31357, 31786, 32138, 32413, 32610, 32729,
        32768
    };

    typedef struct {
        t_sample sine;
        t_sample cosine;
    } t_sincos;

    logic i_clk;
    logic i_rst_n;

    sct_angle_if  angle_ch ();
    sct_result_if result_ch ();

    sine_cosine_table_interp u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_angle_ch  (angle_ch),
        .o_result_ch (result_ch)
    );

    // Angle words waiting to be offered, and sine/cosine pairs still due.
    t_angle  angle_backlog [$];
    t_sincos sincos_due    [$];

    int unsigned angles_queued  = 0;
    int unsigned angles_taken   = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned directed_count = 0;

    // Idle rates in percent, changed only by the stimulus process between
    // phases, right after a rising edge so the falling-edge drivers see a
    // settled value.
    int unsigned send_idle_pct = 0;
    int unsigned sink_idle_pct = 0;

    // A long output stall is requested by bumping hold_seq.
    int unsigned hold_seq  = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;

    logic angle_took;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Linear blend between two table entries over one segment, rounded half
    // up back to Q1.15. The span runs from 0 to QUARTER_TURN over the segment.
    function automatic int unsigned blend(int unsigned lo, int unsigned hi,
                                          int unsigned span);
        return (lo * (QUARTER_TURN - span) + hi * span + QUARTER_TURN / 2)
               >> QUARTER_BITS;
    endfunction

    // Applies the quadrant sign. A positive 1.0 saturates, a negative 1.0
    // stays representable, and a negated zero is zero.
    function automatic t_sample signed_q15(int unsigned mag, bit neg);
        logic [31:0] w;
        if (neg) begin
            w = 32'h0001_0000 - mag;
            return t_sample'(w[OUT_W-1:0]);
        end
        if (mag > 32767)
            return t_sample'(16'h7FFF);
        w = mag;
        return t_sample'(w[OUT_W-1:0]);
    endfunction

    function automatic t_sincos predict_sincos(t_angle ang);
        int unsigned pos;
        int unsigned seg;
        int unsigned span;
        int unsigned sin_mag;
        int unsigned cos_mag;
        bit          upper;
        bit          mirrored;
        t_sincos     r;
        pos   = ang;
        // The lower half turn includes its end point; the upper half is
        // brought down by a half turn with the sine negated.
        upper = pos > HALF_TURN;
        if (upper)
            pos = pos - HALF_TURN;
        // The second quadrant is mirrored onto the first, cosine negated.
        mirrored = pos > QUARTER_TURN;
        if (mirrored)
            pos = HALF_TURN - pos;
        seg  = (pos * SEGMENTS) >> QUARTER_BITS;
        span = (pos * SEGMENTS) & (QUARTER_TURN - 1);
        // An exact quarter turn lands on the last segment with a full span.
        if (seg >= SEGMENTS) begin
            seg  = SEGMENTS - 1;
            span = QUARTER_TURN;
        end
        sin_mag = blend(QUARTER_WAVE[seg], QUARTER_WAVE[seg + 1], span);
        cos_mag = blend(QUARTER_WAVE[SEGMENTS - seg],
                        QUARTER_WAVE[SEGMENTS - seg - 1], span);
        r.sine   = signed_q15(sin_mag, upper);
        r.cosine = signed_q15(cos_mag, upper ^ mirrored);
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF_NS) i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Angle driver: offers the next queued word at the falling edge once the
    // previous one was taken, idling at random between words.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            angle_ch.valid <= 1'b0;
        end else if (!angle_ch.valid || angle_took) begin
            if (angle_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                angle_ch.angle <= angle_backlog.pop_front();
                angle_ch.valid <= 1'b1;
            end else begin
                angle_ch.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result ready: random back-pressure, or a long hold when one is asked.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen       <= hold_seq;
            hold_left       <= HOLD_CYCLES;
            result_ch.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: predicts on every accepted angle word and checks every
    // accepted result word against the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_sincos want;
        if (!i_rst_n) begin
            angle_took <= 1'b0;
        end else begin
            angle_took <= angle_ch.valid && angle_ch.ready;
            if (angle_ch.valid && angle_ch.ready) begin
                sincos_due.push_back(predict_sincos(angle_ch.angle));
                angles_taken <= angles_taken + 1;
            end
            if (result_ch.valid && result_ch.ready) begin
                results_seen <= results_seen + 1;
                if (sincos_due.size() == 0) begin
                    $error("unexpected result word: sine %0d cosine %0d",
                           result_ch.sine, result_ch.cosine);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    want = sincos_due.pop_front();
                    if (result_ch.sine !== want.sine) begin
                        $error("sine: expected %0d, got %0d", want.sine, result_ch.sine);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (result_ch.cosine !== want.cosine) begin
                        $error("cosine: expected %0d, got %0d",
                               want.cosine, result_ch.cosine);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_angle(t_angle ang);
        angle_backlog.push_back(ang);
        angles_queued = angles_queued + 1;
    endtask

    // Random words: half uniform over the turn, the rest clustered around the
    // quadrant edges and the segment edges where folding and clamping act.
    task automatic queue_random(int unsigned n);
        int unsigned pick;
        logic [31:0] raw;
        repeat (n) begin
            pick = $urandom_range(3);
            case (pick)
                0, 1: begin
                    raw = $urandom;
                end
                2: begin
                    raw = $urandom_range(3) * QUARTER_TURN + $urandom_range(8) - 4;
                end
                default: begin
                    raw = ($urandom_range(127) << (QUARTER_BITS - SEG_BITS))
                          + $urandom_range(4) - 2;
                end
            endcase
            queue_angle(t_angle'(raw[ANGLE_W-1:0]));
        end
    endtask

    task automatic wait_drained();
        while (angles_taken != angles_queued || sincos_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        t_angle directed [$];
        directed = '{
            16'h0000, 16'h0001, 16'h01FF, 16'h0200, 16'h2000, 16'h3DFF,
            16'h3E00, 16'h3FFF, 16'h4000, 16'h4001, 16'h6000, 16'h7FFF,
            16'h8000, 16'h8001, 16'hA000, 16'hBFFF, 16'hC000, 16'hC001,
            16'hE000, 16'hFFFE, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h7E00
        };

        i_rst_n         = 1'b0;
        angle_ch.valid  = 1'b0;
        angle_ch.angle  = '0;
        result_ch.ready = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Phase one: sparse sender, slow receiver. The directed words go
        // first: zero, quadrant edges, the exact quarter turn clamp, half
        // and three-quarter turns, and the top of the range.
        @(posedge i_clk);
        send_idle_pct = 33;
        sink_idle_pct = 70;
        foreach (directed[i])
            queue_angle(directed[i]);
        directed_count = directed.size();
        queue_random(620);
        wait_drained();

        // Phase two: the idle rates swap sides.
        @(posedge i_clk);
        send_idle_pct = 70;
        sink_idle_pct = 33;
        queue_random(640);
        wait_drained();

        // Phase three: full rate both ways, with one long output stall while
        // the sender keeps offering words.
        @(posedge i_clk);
        send_idle_pct = 0;
        sink_idle_pct = 0;
        queue_random(640);
        hold_seq = hold_seq + 1;
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);

        $display("Checked %0d sine/cosine words from %0d angles (%0d directed).",
                 results_seen, angles_taken, directed_count);
        $display("Phases: sparse input, sparse output, full rate with a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timed out with %0d of %0d angles taken.", angles_taken, angles_queued);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
